>>> hdl/chf_pkg.sv
// Shared types, constants and helper functions of the cone hit fraction block.
package chf_pkg;

  localparam int DEF_MAX_HITS    = 4096;
  localparam int DEF_COORD_WIDTH = 20;

  localparam int CLAMP_W = 24;   // coordinates after clamping
  localparam int AXIS_W  = 16;   // axis direction, Q1.15
  localparam int APEX_W  = 22;   // cone apex, 1/64 mm
  localparam int VEC_W   = 25;   // working difference vector
  localparam int PAR_W   = 28;   // parallel distance
  localparam int MUL_W   = 28;   // multiplier operands
  localparam int ACC_W   = 56;   // product and accumulator
  localparam int RAD_W   = 52;   // square root radicand
  localparam int ROOT_W  = RAD_W / 2;
  localparam int DVD_W   = 42;   // divider dividend and quotient
  localparam int DVS_W   = ROOT_W;
  localparam int DIST_W  = 22;
  localparam int COS_W   = 16;
  localparam int FRAC_W  = 17;
  localparam int STAT_W  = 2;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 22;

  localparam int COORD_LIMIT = 8388607;
  localparam int APEX_LIMIT  = 2097151;
  localparam int COS_LIMIT   = 32767;
  localparam int HALF_Q15    = 16384;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Operation codes carried in tuser
  localparam logic [1:0] OP_AXIS = 2'd0;
  localparam logic [1:0] OP_ICPT = 2'd1;
  localparam logic [1:0] OP_CENT = 2'd2;
  localparam logic [1:0] OP_HIT  = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_RADIAL = 2'd1;
  localparam logic [STAT_W-1:0] ST_SEP    = 2'd2;
  localparam logic [STAT_W-1:0] ST_ZERO   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_CONE_COS = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_MIN_RAD  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_CUT1_COS = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_CUT1_SEP = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_CUT2_COS = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_CUT2_SEP = 3'd5;

  localparam logic signed [COS_W-1:0] RST_CONE_COS = 16'sd29491;
  localparam logic signed [COS_W-1:0] RST_MIN_RAD  = 16'sd8192;
  localparam logic signed [COS_W-1:0] RST_CUT1_COS = 16'sd16384;
  localparam logic [DIST_W-1:0]       RST_CUT1_SEP = 22'd2024;
  localparam logic signed [COS_W-1:0] RST_CUT2_COS = 16'sd24576;
  localparam logic [DIST_W-1:0]       RST_CUT2_SEP = 22'd2479;

  typedef enum logic [1:0] {
    MAC_DOT,
    MAC_SQ,
    MAC_APEX
  } mac_mode_e;

  typedef enum logic {
    DIV_COS,
    DIV_FRAC
  } div_sel_e;

  typedef struct packed {
    logic      capture;
    logic      ld_axis;
    logic      ld_icpt;
    logic      diff_icpt;
    logic      diff_apex;
    logic      mac_en;
    mac_mode_e mac_mode;
    logic [1:0] step;
    logic      ld_par;
    logic      ld_vapex;
    logic      sqrt_start;
    logic      div_start;
    div_sel_e  div_sel;
    logic      rcos_wr;
    logic      hit_upd;
    logic      stat_ld;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       last;
    logic       sqrt_done;
    logic       div_done;
    logic       mag_zero;
    logic       need_frac;
    logic       out_free;
  } sts_t;

  // Divide by 2^15, rounding half away from zero
  function automatic logic signed [ACC_W-1:0] round_q15(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] m;
    logic signed [ACC_W-1:0] r;
    m = v[ACC_W-1] ? -v : v;
    r = (m + ACC_W'(HALF_Q15)) >>> 15;
    return v[ACC_W-1] ? -r : r;
  endfunction

endpackage

>>> hdl/chf_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module chf_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [chf_pkg::RAD_W-1:0]    rad_i,
  output logic                         done_o,
  output logic [chf_pkg::ROOT_W-1:0]   root_o
);

  localparam int RW  = chf_pkg::ROOT_W;
  localparam int REW = RW + 2;
  localparam int CW  = $clog2(RW + 1);

  logic [chf_pkg::RAD_W-1:0] rad_q;
  logic [REW-1:0]            rem_q;
  logic [RW-1:0]             root_q;
  logic [CW-1:0]             cnt_q;
  logic                      busy_q, done_q;
  logic [REW+1:0]            rem_n, trial;

  assign rem_n  = {rem_q, rad_q[chf_pkg::RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(RW);
        root_q <= '0;
      end else if (busy_q) begin
        if (rem_n >= trial) begin
          root_q <= {root_q[RW-2:0], 1'b1};
        end else begin
          root_q <= {root_q[RW-2:0], 1'b0};
        end
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q <= rad_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[chf_pkg::RAD_W-3:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q <= REW'(rem_n - trial);
      end else begin
        rem_q <= REW'(rem_n);
      end
    end
  end

endmodule

>>> hdl/chf_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module chf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [chf_pkg::DVD_W-1:0]   dvd_i,
  input  logic [chf_pkg::DVS_W-1:0]   dvs_i,
  output logic                        done_o,
  output logic [chf_pkg::DVD_W-1:0]   quot_o
);

  localparam int NW = chf_pkg::DVD_W;
  localparam int SW = chf_pkg::DVS_W;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dq_q;
  logic [SW-1:0] dvs_q, rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [SW:0]   rem_n;
  logic          ge;

  assign rem_n  = {rem_q, dq_q[NW-1]};
  assign ge     = rem_n >= {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = dq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dvd_i;
      dvs_q <= dvs_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q <= {dq_q[NW-2:0], ge};
      if (ge) begin
        rem_q <= SW'(rem_n - {1'b0, dvs_q});
      end else begin
        rem_q <= SW'(rem_n);
      end
    end
  end

endmodule

>>> hdl/chf_dp.sv
// Datapath: cone state, shared multiplier and accumulator, root and divide units, result.
module chf_dp #(
  parameter int MAX_HITS    = chf_pkg::DEF_MAX_HITS,
  parameter int COORD_WIDTH = chf_pkg::DEF_COORD_WIDTH,
  parameter int CNT_W       = $clog2(MAX_HITS + 1),
  parameter int IN_W        = ((3 * COORD_WIDTH + 7) / 8) * 8,
  parameter int OUT_W       = ((chf_pkg::FRAC_W + 2 * CNT_W + chf_pkg::STAT_W + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [chf_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [chf_pkg::CFG_DW-1:0]  cfg_wdata_i,
  input  logic [IN_W-1:0]             in_data_i,
  input  logic [1:0]                  in_user_i,
  input  logic                        in_last_i,
  input  chf_pkg::cmd_t               cmd_i,
  output chf_pkg::sts_t               sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [OUT_W-1:0]            out_data_o
);

  localparam int CLW = chf_pkg::CLAMP_W;
  localparam int AW  = chf_pkg::ACC_W;
  localparam logic signed [32:0] CL_HI = 33'(chf_pkg::COORD_LIMIT);
  localparam logic signed [32:0] CL_LO = -CL_HI - 33'sd1;
  localparam logic signed [CLW-1:0] AX_HI = CLW'(chf_pkg::COS_LIMIT);
  localparam logic signed [CLW-1:0] AX_LO = -AX_HI - CLW'(1);
  localparam logic signed [AW-1:0] APX_HI = AW'(chf_pkg::APEX_LIMIT);
  localparam logic signed [AW-1:0] APX_LO = -APX_HI - AW'(1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_HITS);

  // configuration
  logic signed [15:0] cone_cos_q, min_rad_q, cut1_cos_q, cut2_cos_q;
  logic [chf_pkg::DIST_W-1:0] cut1_sep_q, cut2_sep_q;

  // cone and item state
  logic signed [CLW-1:0]             cin_q   [3];
  logic signed [chf_pkg::AXIS_W-1:0] axis_q  [3];
  logic signed [CLW-1:0]             icpt_q  [3];
  logic signed [chf_pkg::APEX_W-1:0] apex_q  [3];
  logic signed [chf_pkg::VEC_W-1:0]  vec_q   [3];
  logic signed [chf_pkg::PAR_W-1:0]  par_q;
  logic signed [AW-1:0]              prod_q, acc_q;
  logic signed [chf_pkg::COS_W-1:0]  rcos_q;
  logic [1:0]                        op_q;
  logic                              last_q;
  logic [CNT_W-1:0]                  hit_cnt_q, in_cnt_q;
  logic [chf_pkg::DIST_W-1:0]        near_q;
  logic                              zseen_q;
  logic [chf_pkg::STAT_W-1:0]        stat_q;
  logic                              fuse_q;
  logic                              out_valid_q;
  logic [chf_pkg::FRAC_W-1:0]        frac_q;
  logic [CNT_W-1:0]                  out_in_q, out_tot_q;
  logic [chf_pkg::STAT_W-1:0]        out_stat_q;

  logic signed [CLW-1:0] cl [3];

  for (genvar i = 0; i < 3; i++) begin : g_clamp
    logic signed [32:0] ext;
    assign ext   = 33'($signed(in_data_i[i*COORD_WIDTH +: COORD_WIDTH]));
    assign cl[i] = (ext > CL_HI) ? CLW'(CL_HI) : (ext < CL_LO) ? CLW'(CL_LO) : ext[CLW-1:0];
  end

  // multiplier operand selection
  logic signed [chf_pkg::VEC_W-1:0]  vsel;
  logic signed [chf_pkg::AXIS_W-1:0] asel;
  logic signed [CLW-1:0]             isel;
  logic signed [chf_pkg::MUL_W-1:0]  opa, opb;
  logic signed [AW-1:0]              prod_d, apx_sum;
  logic signed [chf_pkg::APEX_W-1:0] apx_new;

  always_comb begin
    vsel = '0;
    asel = '0;
    isel = '0;
    case (cmd_i.step)
      2'd0: begin
        vsel = vec_q[0];
        asel = axis_q[0];
      end
      2'd1: begin
        vsel = vec_q[1];
        asel = axis_q[1];
        isel = icpt_q[0];
      end
      2'd2: begin
        vsel = vec_q[2];
        asel = axis_q[2];
        isel = icpt_q[1];
      end
      default: begin
        isel = icpt_q[2];
      end
    endcase
  end

  always_comb begin
    case (cmd_i.mac_mode)
      chf_pkg::MAC_SQ: begin
        opa = chf_pkg::MUL_W'(vsel);
        opb = chf_pkg::MUL_W'(vsel);
      end
      chf_pkg::MAC_APEX: begin
        opa = chf_pkg::MUL_W'(asel);
        opb = par_q;
      end
      default: begin
        opa = chf_pkg::MUL_W'(vsel);
        opb = chf_pkg::MUL_W'(asel);
      end
    endcase
  end

  assign prod_d  = opa * opb;
  assign apx_sum = AW'(isel) + chf_pkg::round_q15(prod_q);
  assign apx_new = (apx_sum > APX_HI) ? chf_pkg::APEX_W'(APX_HI) :
                   (apx_sum < APX_LO) ? chf_pkg::APEX_W'(APX_LO) :
                   apx_sum[chf_pkg::APEX_W-1:0];

  // square root and divide units
  logic [chf_pkg::ROOT_W-1:0] root;
  logic [chf_pkg::DVD_W-1:0]  quot, dvd;
  logic [chf_pkg::DVS_W-1:0]  dvs;
  logic                       sqrt_done, div_done;
  logic signed [AW-1:0]       acc_abs;
  logic                       acc_neg;

  assign acc_neg = acc_q[AW-1];
  assign acc_abs = acc_neg ? -acc_q : acc_q;
  assign dvd = (cmd_i.div_sel == chf_pkg::DIV_FRAC) ?
               chf_pkg::DVD_W'({in_cnt_q, 16'b0}) : acc_abs[chf_pkg::DVD_W-1:0];
  assign dvs = (cmd_i.div_sel == chf_pkg::DIV_FRAC) ?
               chf_pkg::DVS_W'(hit_cnt_q) : root;

  chf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (acc_q[chf_pkg::RAD_W-1:0]),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  chf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .dvd_i   (dvd),
    .dvs_i   (dvs),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // cosine from the quotient, saturated to Q1.15
  logic                             mag_zero;
  logic signed [chf_pkg::COS_W-1:0] cos_val;
  logic [chf_pkg::DIST_W-1:0]       dist_sat;

  assign mag_zero = (root == '0);
  assign dist_sat = (root > chf_pkg::ROOT_W'(chf_pkg::DIST_MAX)) ?
                    chf_pkg::DIST_MAX : root[chf_pkg::DIST_W-1:0];

  always_comb begin
    if (mag_zero) begin
      cos_val = '0;
    end else if (!acc_neg) begin
      cos_val = (quot > chf_pkg::DVD_W'(32767)) ? 16'sh7fff : quot[15:0];
    end else begin
      cos_val = (quot > chf_pkg::DVD_W'(32768)) ? 16'sh8000 : 16'(16'd0 - quot[15:0]);
    end
  end

  // result status
  logic                       apex_zero, radial_rej, cut_rej;
  logic [chf_pkg::STAT_W-1:0] stat_d;

  assign apex_zero  = (apex_q[0] == '0) && (apex_q[1] == '0) && (apex_q[2] == '0);
  assign radial_rej = apex_zero || (rcos_q < min_rad_q);
  assign cut_rej    = ((rcos_q < cut1_cos_q) && (near_q > cut1_sep_q)) ||
                      ((rcos_q < cut2_cos_q) && (near_q > cut2_sep_q));
  assign stat_d     = radial_rej ? chf_pkg::ST_RADIAL :
                      zseen_q    ? chf_pkg::ST_ZERO   :
                      cut_rej    ? chf_pkg::ST_SEP    : chf_pkg::ST_OK;

  always_comb begin
    sts_o           = '0;
    sts_o.op        = op_q;
    sts_o.last      = last_q;
    sts_o.sqrt_done = sqrt_done;
    sts_o.div_done  = div_done;
    sts_o.mag_zero  = mag_zero;
    sts_o.need_frac = (stat_d == chf_pkg::ST_OK) && (hit_cnt_q != '0);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cone_cos_q <= chf_pkg::RST_CONE_COS;
      min_rad_q  <= chf_pkg::RST_MIN_RAD;
      cut1_cos_q <= chf_pkg::RST_CUT1_COS;
      cut1_sep_q <= chf_pkg::RST_CUT1_SEP;
      cut2_cos_q <= chf_pkg::RST_CUT2_COS;
      cut2_sep_q <= chf_pkg::RST_CUT2_SEP;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        chf_pkg::CFG_CONE_COS: cone_cos_q <= cfg_wdata_i[15:0];
        chf_pkg::CFG_MIN_RAD:  min_rad_q  <= cfg_wdata_i[15:0];
        chf_pkg::CFG_CUT1_COS: cut1_cos_q <= cfg_wdata_i[15:0];
        chf_pkg::CFG_CUT1_SEP: cut1_sep_q <= cfg_wdata_i;
        chf_pkg::CFG_CUT2_COS: cut2_cos_q <= cfg_wdata_i[15:0];
        chf_pkg::CFG_CUT2_SEP: cut2_sep_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // cone state and hit accumulation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        axis_q[i] <= '0;
        icpt_q[i] <= '0;
        apex_q[i] <= '0;
      end
      rcos_q      <= '0;
      hit_cnt_q   <= '0;
      in_cnt_q    <= '0;
      near_q      <= chf_pkg::DIST_MAX;
      zseen_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ld_axis) begin
        for (int i = 0; i < 3; i++) begin
          axis_q[i] <= (cin_q[i] > AX_HI) ? 16'sh7fff :
                       (cin_q[i] < AX_LO) ? 16'sh8000 : cin_q[i][15:0];
        end
      end
      if (cmd_i.ld_icpt) begin
        for (int i = 0; i < 3; i++) icpt_q[i] <= cin_q[i];
      end
      if (cmd_i.mac_en && cmd_i.mac_mode == chf_pkg::MAC_APEX) begin
        case (cmd_i.step)
          2'd1:    apex_q[0] <= apx_new;
          2'd2:    apex_q[1] <= apx_new;
          2'd3:    apex_q[2] <= apx_new;
          default: ;
        endcase
      end
      if (cmd_i.rcos_wr) rcos_q <= cos_val;
      if (cmd_i.hit_upd) begin
        if (hit_cnt_q < CNT_MAX) hit_cnt_q <= hit_cnt_q + CNT_W'(1);
        if (mag_zero) begin
          zseen_q <= 1'b1;
        end else begin
          if (dist_sat < near_q) near_q <= dist_sat;
          if ((cos_val > cone_cos_q) && (in_cnt_q < CNT_MAX)) in_cnt_q <= in_cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        hit_cnt_q   <= '0;
        in_cnt_q    <= '0;
        near_q      <= chf_pkg::DIST_MAX;
        zseen_q     <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int i = 0; i < 3; i++) cin_q[i] <= cl[i];
      op_q   <= in_user_i;
      last_q <= in_last_i;
    end
    if (cmd_i.diff_icpt) begin
      for (int i = 0; i < 3; i++) vec_q[i] <= chf_pkg::VEC_W'(cin_q[i]) - chf_pkg::VEC_W'(icpt_q[i]);
    end
    if (cmd_i.diff_apex) begin
      for (int i = 0; i < 3; i++) vec_q[i] <= chf_pkg::VEC_W'(cin_q[i]) - chf_pkg::VEC_W'(apex_q[i]);
    end
    if (cmd_i.ld_vapex) begin
      for (int i = 0; i < 3; i++) vec_q[i] <= chf_pkg::VEC_W'(apex_q[i]);
    end
    if (cmd_i.mac_en) begin
      prod_q <= prod_d;
      if (cmd_i.mac_mode != chf_pkg::MAC_APEX) begin
        acc_q <= (cmd_i.step == 2'd0) ? '0 : acc_q + prod_q;
      end
    end
    if (cmd_i.ld_par) par_q <= chf_pkg::PAR_W'(chf_pkg::round_q15(acc_q));
    if (cmd_i.stat_ld) begin
      stat_q <= stat_d;
      fuse_q <= sts_o.need_frac;
    end
    if (cmd_i.emit) begin
      frac_q     <= fuse_q ? quot[chf_pkg::FRAC_W-1:0] : '0;
      out_in_q   <= in_cnt_q;
      out_tot_q  <= hit_cnt_q;
      out_stat_q <= stat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = OUT_W'({out_stat_q, out_tot_q, out_in_q, frac_q});

endmodule

>>> hdl/chf_ctrl.sv
// Controller: sequences each item's steps through the datapath.
module chf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  chf_pkg::sts_t  sts_i,
  output chf_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_PDOT   = 4'd2;
  localparam logic [3:0] S_PAR    = 4'd3;
  localparam logic [3:0] S_APEX   = 4'd4;
  localparam logic [3:0] S_VAPEX  = 4'd5;
  localparam logic [3:0] S_SQ     = 4'd6;
  localparam logic [3:0] S_SQST   = 4'd7;
  localparam logic [3:0] S_SQW    = 4'd8;
  localparam logic [3:0] S_CDOT   = 4'd9;
  localparam logic [3:0] S_CDIVST = 4'd10;
  localparam logic [3:0] S_CDIVW  = 4'd11;
  localparam logic [3:0] S_COSW   = 4'd12;
  localparam logic [3:0] S_STAT   = 4'd13;
  localparam logic [3:0] S_FDIV   = 4'd14;
  localparam logic [3:0] S_EMIT   = 4'd15;

  logic [3:0] state_q, state_d;
  logic [1:0] step_q, step_d;
  logic       step_end;

  assign step_end   = (step_q == 2'd3);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = 2'd0;
    cmd_o   = '0;
    cmd_o.step     = step_q;
    cmd_o.mac_mode = chf_pkg::MAC_DOT;
    cmd_o.div_sel  = chf_pkg::DIV_COS;
    case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = S_DISP;
      end
      S_DISP: begin
        case (sts_i.op)
          chf_pkg::OP_AXIS: begin
            cmd_o.ld_axis = 1'b1;
            state_d = S_IDLE;
          end
          chf_pkg::OP_ICPT: begin
            cmd_o.ld_icpt = 1'b1;
            state_d = S_IDLE;
          end
          chf_pkg::OP_CENT: begin
            cmd_o.diff_icpt = 1'b1;
            state_d = S_PDOT;
          end
          default: begin
            cmd_o.diff_apex = 1'b1;
            state_d = S_SQ;
          end
        endcase
      end
      S_PDOT, S_SQ, S_CDOT, S_APEX: begin
        cmd_o.mac_en = 1'b1;
        cmd_o.mac_mode = (state_q == S_SQ)   ? chf_pkg::MAC_SQ :
                         (state_q == S_APEX) ? chf_pkg::MAC_APEX : chf_pkg::MAC_DOT;
        step_d = step_q + 2'd1;
        if (step_end) begin
          step_d = 2'd0;
          case (state_q)
            S_PDOT:  state_d = S_PAR;
            S_APEX:  state_d = S_VAPEX;
            S_SQ:    state_d = S_SQST;
            default: state_d = S_CDIVST;
          endcase
        end
      end
      S_PAR: begin
        cmd_o.ld_par = 1'b1;
        state_d = S_APEX;
      end
      S_VAPEX: begin
        cmd_o.ld_vapex = 1'b1;
        state_d = S_SQ;
      end
      S_SQST: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = S_SQW;
      end
      S_SQW: begin
        if (sts_i.sqrt_done) state_d = S_CDOT;
      end
      S_CDIVST: begin
        if (sts_i.mag_zero) begin
          state_d = S_COSW;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_CDIVW;
        end
      end
      S_CDIVW: begin
        if (sts_i.div_done) state_d = S_COSW;
      end
      S_COSW: begin
        if (sts_i.op == chf_pkg::OP_CENT) begin
          cmd_o.rcos_wr = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.hit_upd = 1'b1;
          state_d = sts_i.last ? S_STAT : S_IDLE;
        end
      end
      S_STAT: begin
        cmd_o.stat_ld = 1'b1;
        cmd_o.div_sel = chf_pkg::DIV_FRAC;
        if (sts_i.need_frac) begin
          cmd_o.div_start = 1'b1;
          state_d = S_FDIV;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_FDIV: begin
        if (sts_i.div_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

>>> hdl/cone_hit_fraction_top.sv
// Top level of the cone hit fraction block: controller, datapath and stream ports.
//
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser operation, tdata coords, tlast last hit
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata fraction, counts, status
// cfg       in         cfg_we_i (no wait)            cfg_addr_i index, cfg_wdata_i value
//
// Axis and intercept loads end in the dispatch state. A hit (with no divide when its distance is
// zero) and a centroid both run the 26-step square root and the 42-step divider, which are shared.
// A last hit then loads the status and, when a fraction is needed, runs the fraction divide.
// One item is in work at a time; the next is accepted while a result waits in the output
// register, and a finished result waits for that register to drain. Reset is asynchronous.
module cone_hit_fraction_top #(
  parameter int MAX_HITS    = chf_pkg::DEF_MAX_HITS,
  parameter int COORD_WIDTH = chf_pkg::DEF_COORD_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [chf_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [chf_pkg::CFG_DW-1:0]  cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // coord_x, coord_y, coord_z, zero pad
  input  logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // operation
  input  logic [1:0]                  s_axis_tuser,
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // fraction_in_cone, hits_in_cone, hit_total, status, zero pad
  output logic [((chf_pkg::FRAC_W + 2 * $clog2(MAX_HITS + 1) + chf_pkg::STAT_W + 7) / 8) * 8 - 1:0]
                                      m_axis_tdata
);

  localparam int CNT_W = $clog2(MAX_HITS + 1);
  localparam int IN_W  = ((3 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_W = ((chf_pkg::FRAC_W + 2 * CNT_W + chf_pkg::STAT_W + 7) / 8) * 8;

  chf_pkg::cmd_t cmd;
  chf_pkg::sts_t sts;

  chf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  chf_dp #(
    .MAX_HITS    (MAX_HITS),
    .COORD_WIDTH (COORD_WIDTH),
    .CNT_W       (CNT_W),
    .IN_W        (IN_W),
    .OUT_W       (OUT_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  localparam int F_W = chf_pkg::FRAC_W;

  // in-cone count never exceeds the total on a result
  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[F_W +: CNT_W] <= m_axis_tdata[F_W + CNT_W +: CNT_W]))
    else $error("hits_in_cone above hit_total");

  // a nonzero fraction only comes with an ok status
  a_frac_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[F_W-1:0] != '0)) |->
    (m_axis_tdata[F_W + 2*CNT_W +: chf_pkg::STAT_W] == chf_pkg::ST_OK))
    else $error("nonzero fraction on a rejected result");

  // an accepted item cannot produce a result in the following cycle
  a_no_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
    else $error("result raised right after an accept");

endmodule
